[design/rgbhsv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared widths, constants, types and the value scaling function of the
// RGB to HSV converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

	localparam int unsigned ChanW     = 8;
	localparam int unsigned QuotW     = 15;
	localparam int unsigned NumW      = ChanW + QuotW;
	localparam int unsigned OutW      = 15;
	localparam int unsigned MagW      = 12;
	localparam int unsigned CellCount = QuotW;

	localparam logic [OutW-1:0] HueFull  = 15'd23040;
	localparam logic [OutW-1:0] HueBaseG = 15'd7680;
	localparam logic [OutW-1:0] HueBaseB = 15'd15360;
	localparam logic [OutW-1:0] PctScale = 15'd25600;
	localparam logic [MagW-1:0] HueSixth = 12'd3840;
	localparam logic [6:0]      ValMul   = 7'd100;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	typedef struct packed {
		logic [OutW-1:0] val;
		sector_t         sector;
		logic            neg;
	} side_t;

	// Partial remainders, dividend/quotient shift words and divisors of the
	// hue and saturation divides, plus the sideband that rides along.
	typedef struct packed {
		logic [ChanW-1:0] rem_hue;
		logic [ChanW-1:0] rem_sat;
		logic [QuotW-1:0] word_hue;
		logic [QuotW-1:0] word_sat;
		logic [ChanW-1:0] div_hue;
		logic [ChanW-1:0] div_sat;
		side_t            side;
	} div_word_t;

	// max * 25600 / 255 = 100*max + (100*max) / 255; the second term uses the
	// exact 16-bit divide-by-255 identity.
	function automatic logic [OutW-1:0] value_pct(input logic [ChanW-1:0] mx);
		logic [15:0] y;
		logic [15:0] t;
		y = 16'(mx) * 16'(ValMul);
		t = (y + (y >> 8) + 16'd1) >> 8;
		return OutW'(y) + OutW'(t);
	endfunction

endpackage

[design/rgbhsv_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_prep
// Input stage: max, min, spread, sector choice and the dividends and
// divisors that feed the divider cell row.
// ----------------------------------------------------------------------------
module rgbhsv_prep (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rgbhsv_pkg::ChanW-1:0]  red_in,
	input  logic [rgbhsv_pkg::ChanW-1:0]  green_in,
	input  logic [rgbhsv_pkg::ChanW-1:0]  blue_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rgbhsv_pkg::div_word_t         out_word
);
	import rgbhsv_pkg::*;

	logic [ChanW-1:0] mx, mn, spread, op_a, op_b, mag_d;
	logic [NumW-1:0]  hue_num, sat_num;
	sector_t          sector;
	logic             neg;
	div_word_t        word;
	logic             take;
	logic             valid_s1;
	div_word_t        word_s1;

	always_comb begin
		mx = red_in;
		mn = red_in;
		if (green_in > mx) mx = green_in;
		if (blue_in > mx) mx = blue_in;
		if (green_in < mn) mn = green_in;
		if (blue_in < mn) mn = blue_in;
		spread = mx - mn;

		// ties go to red, then green
		if (mx == red_in) begin
			sector = SEC_RED;
			op_a   = green_in;
			op_b   = blue_in;
		end else if (mx == green_in) begin
			sector = SEC_GREEN;
			op_a   = blue_in;
			op_b   = red_in;
		end else begin
			sector = SEC_BLUE;
			op_a   = red_in;
			op_b   = green_in;
		end
		neg   = op_a < op_b;
		mag_d = neg ? op_b - op_a : op_a - op_b;

		hue_num = NumW'(mag_d) * NumW'(HueSixth);
		sat_num = NumW'(spread) * NumW'(PctScale);

		// a zero divisor only comes with a zero dividend: divide by one
		word.div_hue     = (spread == '0) ? ChanW'(1) : spread;
		word.div_sat     = (mx == '0) ? ChanW'(1) : mx;
		word.rem_hue     = hue_num[NumW-1:QuotW];
		word.rem_sat     = sat_num[NumW-1:QuotW];
		word.word_hue    = hue_num[QuotW-1:0];
		word.word_sat    = sat_num[QuotW-1:0];
		word.side.val    = value_pct(mx);
		word.side.sector = sector;
		word.side.neg    = neg;
	end

	assign take     = !valid_s1 || out_ready;
	assign in_ready = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			word_s1 <= word;
		end
	end

	assign out_valid = valid_s1;
	assign out_word  = word_s1;

endmodule

[design/rgbhsv_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_div_cell
// One restoring divide step for both the hue and the saturation quotient;
// a row of these cells forms the pipelined divider.
// ----------------------------------------------------------------------------
module rgbhsv_div_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rgbhsv_pkg::div_word_t in_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rgbhsv_pkg::div_word_t out_word
);
	import rgbhsv_pkg::*;

	logic [ChanW:0] trial_hue, trial_sat;
	logic           ge_hue, ge_sat;
	div_word_t      next_word;
	logic           take;
	logic           valid_q;
	div_word_t      word_q;

	always_comb begin
		next_word = in_word;
		// shift the next dividend bit into the remainder, keep the quotient bit
		trial_hue = {in_word.rem_hue, in_word.word_hue[QuotW-1]};
		trial_sat = {in_word.rem_sat, in_word.word_sat[QuotW-1]};
		ge_hue    = trial_hue >= {1'b0, in_word.div_hue};
		ge_sat    = trial_sat >= {1'b0, in_word.div_sat};
		next_word.rem_hue  = ge_hue ? ChanW'(trial_hue - {1'b0, in_word.div_hue})
		                            : trial_hue[ChanW-1:0];
		next_word.rem_sat  = ge_sat ? ChanW'(trial_sat - {1'b0, in_word.div_sat})
		                            : trial_sat[ChanW-1:0];
		next_word.word_hue = {in_word.word_hue[QuotW-2:0], ge_hue};
		next_word.word_sat = {in_word.word_sat[QuotW-2:0], ge_sat};
	end

	assign take     = !valid_q || out_ready;
	assign in_ready = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			word_q <= next_word;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

	a_rem_hue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> word_q.rem_hue < word_q.div_hue)
		else $error("hue remainder not below divisor");

	a_rem_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> word_q.rem_sat < word_q.div_sat)
		else $error("saturation remainder not below divisor");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> valid_q && $stable(word_q))
		else $error("cell item changed while stalled");

endmodule

[design/rgbhsv_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_out
// Output stage: adds the hue offset to, or subtracts it from, the sector base
// with wrap and holds the result item until it is taken.
// ----------------------------------------------------------------------------
module rgbhsv_out (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  rgbhsv_pkg::div_word_t        in_word,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rgbhsv_pkg::OutW-1:0]  hue_out,
	output logic [rgbhsv_pkg::OutW-1:0]  sat_out,
	output logic [rgbhsv_pkg::OutW-1:0]  val_out
);
	import rgbhsv_pkg::*;

	logic [OutW-1:0] base, mag, hue;
	logic            take;
	logic            valid_q;
	logic [OutW-1:0] hue_q, sat_q, val_q;

	always_comb begin
		case (in_word.side.sector)
			SEC_RED:   base = '0;
			SEC_GREEN: base = HueBaseG;
			SEC_BLUE:  base = HueBaseB;
			default:   base = '0;
		endcase
		mag = OutW'(in_word.word_hue[MagW-1:0]);
		if (!in_word.side.neg) begin
			hue = base + mag;
		end else if (mag > base) begin
			// only the red sector can go below zero: wrap
			hue = base + HueFull - mag;
		end else begin
			hue = base - mag;
		end
	end

	assign take     = !valid_q || out_ready;
	assign in_ready = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			hue_q <= hue;
			sat_q <= in_word.word_sat;
			val_q <= in_word.side.val;
		end
	end

	assign out_valid = valid_q;
	assign hue_out   = hue_q;
	assign sat_out   = sat_q;
	assign val_out   = val_q;

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> hue_q < HueFull)
		else $error("hue out of range");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> sat_q <= PctScale && val_q <= PctScale)
		else $error("saturation or value out of range");

	a_sat_le_val: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && val_q == '0 |-> sat_q == '0 && hue_q == '0)
		else $error("black pixel with nonzero hue or saturation");

endmodule

[design/rgb_to_hsv_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_core
// Converts one 8-bit RGB pixel per item into hue (1/64 degree), saturation
// and value (1/256 percent), all truncated.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries red_in, green_in, blue_in; the
//   output channel out_valid/out_ready carries hue_out, sat_out, val_out.
//   Every input item gives exactly one result item, in order.
//   Each item passes one input stage, a row of 15 divider cells (one
//   quotient bit per cell for both the hue and the saturation divide)
//   and one output register; one item per cycle while out_ready is high.
//   Each stage has its own valid bit and takes a new item whenever it is
//   empty or its item moves on, so a stalled receiver only backs up the
//   pipeline stage by stage; in_ready falls once all 17 stages are full.
//   Reset clears every valid bit; no item is in flight afterwards and the
//   block accepts input as soon as reset is released.
// ----------------------------------------------------------------------------
module rgb_to_hsv_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rgbhsv_pkg::ChanW-1:0] red_in,
	input  logic [rgbhsv_pkg::ChanW-1:0] green_in,
	input  logic [rgbhsv_pkg::ChanW-1:0] blue_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rgbhsv_pkg::OutW-1:0]  hue_out,
	output logic [rgbhsv_pkg::OutW-1:0]  sat_out,
	output logic [rgbhsv_pkg::OutW-1:0]  val_out
);
	import rgbhsv_pkg::*;

	logic      chain_valid [CellCount+1];
	logic      chain_ready [CellCount+1];
	div_word_t chain_word  [CellCount+1];

	rgbhsv_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_word  (chain_word[0])
	);

	for (genvar i = 0; i < CellCount; i++) begin : g_cell
		rgbhsv_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_word   (chain_word[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_word  (chain_word[i+1])
		);
	end

	rgbhsv_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[CellCount]),
		.in_ready  (chain_ready[CellCount]),
		.in_word   (chain_word[CellCount]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hue_out   (hue_out),
		.sat_out   (sat_out),
		.val_out   (val_out)
	);

endmodule

[verif/tb_rgb_to_hsv_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_core
// Self-checking bench for the RGB to HSV converter. Pixels go in through
// the valid/ready input channel. Each accepted pixel is run through a
// local fixed-point HSV calculation and the result is queued. Every result
// that leaves the block is compared field by field with the oldest queued
// value. Both sides insert random idle cycles, except during two calm
// stretches. One phase holds the output side off long enough for the
// pipeline to fill up and stall the input.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_core;
	import rgbhsv_pkg::*;

	typedef struct packed {
		logic [OutW-1:0] hue;
		logic [OutW-1:0] sat;
		logic [OutW-1:0] val;
	} hsv_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [ChanW-1:0]  red_in;
	logic [ChanW-1:0]  green_in;
	logic [ChanW-1:0]  blue_in;
	logic              out_valid;
	logic              out_ready;
	logic [OutW-1:0]   hue_out;
	logic [OutW-1:0]   sat_out;
	logic [OutW-1:0]   val_out;

	hsv_t expected_hsv[$];
	int   err_count  = 0;
	bit   calm       = 1'b0;
	bit   hold_start = 1'b0;
	int   hold_cnt   = 0;

	rgb_to_hsv_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hue_out   (hue_out),
		.sat_out   (sat_out),
		.val_out   (val_out)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("tb_rgb_to_hsv_core: done, errors");
		$finish;
	end

	function automatic logic [OutW-1:0] sector_hue(input int unsigned base, input int unsigned a,
			input int unsigned b, input int unsigned spread);
		int unsigned mag;
		if (a >= b) begin
			mag = ((a - b) * HueSixth) / spread;
			return OutW'((base + mag) % HueFull);
		end
		mag = ((b - a) * HueSixth) / spread;
		return OutW'((base + HueFull - mag) % HueFull);
	endfunction

	function automatic hsv_t predict_hsv(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
			input logic [ChanW-1:0] b);
		int unsigned mx;
		int unsigned mn;
		int unsigned spread;
		sector_t     sec;
		hsv_t        res;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		spread = mx - mn;
		// ties go to red first, then green
		if (mx == r) sec = SEC_RED;
		else if (mx == g) sec = SEC_GREEN;
		else sec = SEC_BLUE;
		if (spread == 0) begin
			res.hue = '0;
		end else begin
			case (sec)
				SEC_RED:   res.hue = sector_hue(0, g, b, spread);
				SEC_GREEN: res.hue = sector_hue(HueBaseG, b, r, spread);
				default:   res.hue = sector_hue(HueBaseB, r, g, spread);
			endcase
		end
		res.sat = (mx == 0) ? '0 : OutW'((spread * PctScale) / mx);
		res.val = OutW'((mx * PctScale) / 255);
		return res;
	endfunction

	// Queue predictions on input accept, check results on output accept.
	always @(posedge clk) begin
		hsv_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_hsv.push_back(predict_hsv(red_in, green_in, blue_in));
			if (out_valid && out_ready) begin
				if (expected_hsv.size() == 0) begin
					$error("unexpected result item: hue %0d sat %0d val %0d",
						hue_out, sat_out, val_out);
					err_count++;
				end else begin
					want = expected_hsv.pop_front();
					if (hue_out !== want.hue) begin
						$error("hue_out: expected %0d, actual %0d", want.hue, hue_out);
						err_count++;
					end
					if (sat_out !== want.sat) begin
						$error("sat_out: expected %0d, actual %0d", want.sat, sat_out);
						err_count++;
					end
					if (val_out !== want.val) begin
						$error("val_out: expected %0d, actual %0d", want.val, val_out);
						err_count++;
					end
				end
			end
		end
	end

	// Receiver: random stalls, plus a counted hold-off on request.
	initial out_ready = 1'b0;
	always @(negedge clk) begin
		if (hold_start) begin
			hold_cnt = 300;
			hold_start = 1'b0;
		end
		if (!arst_n) begin
			out_ready = 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready = 1'b0;
		end else begin
			out_ready = calm || ($urandom_range(0, 99) >= 31);
		end
	end

	// Offer one item; leave valid high on return so back-to-back items stay glued.
	task automatic send_pixel(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
			input logic [ChanW-1:0] b);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 31) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		red_in   = r;
		green_in = g;
		blue_in  = b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic logic [ChanW-1:0] edgy_chan();
		case ($urandom_range(0, 5))
			0:       return 8'd0;
			1:       return 8'd1;
			2:       return 8'd254;
			3:       return 8'd255;
			default: return ChanW'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		send_pixel(8'd0,   8'd0,   8'd0);   // black
		send_pixel(8'd255, 8'd255, 8'd255); // white
		send_pixel(8'd128, 8'd128, 8'd128); // grey
		send_pixel(8'd1,   8'd1,   8'd1);
		send_pixel(8'd255, 8'd0,   8'd0);
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd255, 8'd0,   8'd1);   // red sector wraps below zero
		send_pixel(8'd255, 8'd1,   8'd0);
		send_pixel(8'd0,   8'd255, 8'd1);
		send_pixel(8'd1,   8'd255, 8'd0);
		send_pixel(8'd1,   8'd0,   8'd255);
		send_pixel(8'd0,   8'd1,   8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);   // red/green tie
		send_pixel(8'd255, 8'd0,   8'd255); // red/blue tie
		send_pixel(8'd0,   8'd255, 8'd255); // green/blue tie
		send_pixel(8'd1,   8'd0,   8'd0);
		send_pixel(8'd255, 8'd254, 8'd0);
		send_pixel(8'd170, 8'd85,  8'd0);
		send_pixel(8'd85,  8'd170, 8'd255);
	endtask

	task automatic test_uniform_random(input int count);
		repeat (count) send_pixel(ChanW'($urandom), ChanW'($urandom), ChanW'($urandom));
	endtask

	task automatic test_corner_random(input int count);
		logic [ChanW-1:0] r;
		logic [ChanW-1:0] g;
		logic [ChanW-1:0] b;
		repeat (count) begin
			r = edgy_chan();
			g = edgy_chan();
			b = edgy_chan();
			// force ties and greys now and then
			case ($urandom_range(0, 4))
				0:       g = r;
				1:       b = g;
				2:       begin g = r; b = r; end
				default: ;
			endcase
			send_pixel(r, g, b);
		end
	endtask

	task automatic test_calm_stream(input int count);
		calm = 1'b1;
		test_uniform_random(count);
		calm = 1'b0;
	endtask

	task automatic test_backpressure(input int count);
		hold_start = 1'b1;
		calm = 1'b1;
		test_uniform_random(count);
		calm = 1'b0;
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		red_in   = '0;
		green_in = '0;
		blue_in  = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_uniform_random(250);
		test_calm_stream(150);
		test_backpressure(60);
		test_corner_random(200);

		@(negedge clk);
		in_valid = 1'b0;
		while (expected_hsv.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		if (err_count == 0 && expected_hsv.size() == 0) begin
			$display("tb_rgb_to_hsv_core: done, clean");
		end else begin
			$display("tb_rgb_to_hsv_core: done, errors");
		end
		$finish;
	end

endmodule
